/* sv/gb2312_char_class_tagger_macros.svh */
// Assertion macros shared by the character class tagger checkers.
// Depends on clk and rst_n being visible where the macros are used.
`ifndef GB2312_CHAR_CLASS_TAGGER_MACROS_SVH
`define GB2312_CHAR_CLASS_TAGGER_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define GBCCT_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gbcct check failed");

// Antecedent implies consequent in the next cycle.
`define GBCCT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gbcct check failed");

`endif

/* sv/gbcct_pkg.sv */
// Class codes, character codes and classification functions for the
// GB2312/ASCII character class tagger. No dependencies.
`default_nettype none

package gbcct_pkg;

    localparam logic [2:0] CLS_OTHER  = 3'd0;
    localparam logic [2:0] CLS_LETTER = 3'd1;
    localparam logic [2:0] CLS_NUMBER = 3'd2;
    localparam logic [2:0] CLS_PUNCT  = 3'd3;
    localparam logic [2:0] CLS_SPACE  = 3'd4;
    localparam logic [2:0] CLS_DATE   = 3'd5;

    localparam logic [7:0] CH_DOT    = 8'h2e;
    localparam logic [7:0] CH_COMMA  = 8'h2c;
    localparam logic [7:0] CH_HYPHEN = 8'h2d;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] LEAD_SYM  = 8'ha1;
    localparam logic [7:0] LEAD_FULL = 8'ha3;

    localparam logic [15:0] CODE_OF       = 16'hd6ae;
    localparam logic [15:0] CODE_POINT    = 16'hb5e3;
    localparam logic [15:0] CODE_FRACTION = 16'hb7d6;
    localparam logic [15:0] CODE_MANY     = 16'hb6e0;
    localparam logic [15:0] CODE_REMAIN   = 16'hd3e0;

    localparam int NUM_DIGIT_CODES = 18;
    localparam int NUM_DATE_CODES  = 7;

    localparam logic [15:0] DIGIT_CODES [NUM_DIGIT_CODES] = '{
        16'ha1f0, 16'ha3ae, 16'ha3a5,
        16'hc1e3, 16'hd2bb, 16'hb6fe, 16'hc8fd, 16'hcbc4,
        16'hcee5, 16'hc1f9, 16'hc6df, 16'hb0cb, 16'hbec5,
        16'hcaae, 16'hb0d9, 16'hc7a7, 16'hcdf2, 16'hd2da
    };

    localparam logic [15:0] DATE_CODES [NUM_DATE_CODES] = '{
        16'hc4ea, 16'hd4c2, 16'hc8d5, 16'hcab1, 16'hb7d6, 16'hc3eb, 16'hb5e3
    };

    function automatic logic in_rng(input logic [7:0] v, input logic [7:0] lo,
                                    input logic [7:0] hi);
        return (v >= lo) && (v <= hi);
    endfunction

    function automatic logic is_letter(input logic [7:0] lead, input logic [7:0] trail);
        if (!lead[7])
            return in_rng(lead, 8'h41, 8'h5a) || in_rng(lead, 8'h61, 8'h7a);
        return (lead == LEAD_FULL) &&
               (in_rng(trail, 8'hc1, 8'hda) || in_rng(trail, 8'he1, 8'hfa));
    endfunction

    function automatic logic is_digit(input logic [7:0] lead, input logic [7:0] trail);
        logic hit;
        hit = in_rng(lead, 8'h30, 8'h39) || (lead == CH_PCT) ||
              ((lead == LEAD_FULL) && in_rng(trail, 8'hb0, 8'hb9));
        for (int i = 0; i < NUM_DIGIT_CODES; i++)
            if (lead[7] && ({lead, trail} == DIGIT_CODES[i]))
                hit = 1'b1;
        return hit;
    endfunction

    function automatic logic is_punct(input logic [7:0] lead, input logic [7:0] trail);
        if ((lead == CH_DOT) || (lead == CH_COMMA))
            return 1'b0;
        if (!lead[7])
            return in_rng(lead, 8'h21, 8'h2f) || in_rng(lead, 8'h3a, 8'h40) ||
                   in_rng(lead, 8'h5b, 8'h60) || in_rng(lead, 8'h7b, 8'h7e);
        if ((lead == LEAD_SYM) &&
            (in_rng(trail, 8'ha2, 8'hef) || in_rng(trail, 8'hf1, 8'hfe)))
            return 1'b1;
        return (lead == LEAD_FULL) &&
               (in_rng(trail, 8'ha1, 8'haf) || in_rng(trail, 8'hba, 8'hc0) ||
                in_rng(trail, 8'hdb, 8'he0) || in_rng(trail, 8'hfb, 8'hfe));
    endfunction

    function automatic logic is_space(input logic [7:0] lead, input logic [7:0] trail);
        if (!lead[7])
            return (lead == 8'h20) || in_rng(lead, 8'h09, 8'h0d);
        return (lead == LEAD_SYM) && (trail == LEAD_SYM);
    endfunction

    function automatic logic is_date(input logic [7:0] lead, input logic [7:0] trail);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < NUM_DATE_CODES; i++)
            if (lead[7] && ({lead, trail} == DATE_CODES[i]))
                hit = 1'b1;
        return hit;
    endfunction

endpackage

`default_nettype wire

/* sv/gb2312_char_class_tagger.sv */
// Structure: an input register and a result register sit either side of
// the classification logic. Throughput: one character per cycle when the
// output is not stalled.
// Reset: rst_n clears both stage valid flags; the payload is not reset.
// Stalls on the output back up into the input stage, then into in_ready.
`default_nettype none

module gb2312_char_class_tagger (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] cur_lead_byte,
    input  wire logic [7:0] cur_trail_byte,
    input  wire logic [2:0] prev_class,
    input  wire logic       next_present,
    input  wire logic [7:0] next_lead_byte,
    input  wire logic [7:0] next_trail_byte,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [2:0]      char_class
);
    import gbcct_pkg::*;

    logic       s1_valid_reg;
    logic [7:0] lead_reg;
    logic [7:0] trail_reg;
    logic [2:0] prev_reg;
    logic       has_next_reg;
    logic [7:0] nlead_reg;
    logic [7:0] ntrail_reg;

    logic       out_valid_reg;
    logic [2:0] class_reg;
    logic [2:0] class_next;

    logic out_load;
    logic in_fire;

    assign out_load = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || out_load;
    assign in_fire  = in_valid && in_ready;

    assign out_valid  = out_valid_reg;
    assign char_class = class_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
                s1_valid_reg <= 1'b1;
            else if (out_load)
                s1_valid_reg <= 1'b0;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            lead_reg     <= cur_lead_byte;
            trail_reg    <= cur_trail_byte;
            prev_reg     <= prev_class;
            has_next_reg <= next_present;
            nlead_reg    <= next_lead_byte;
            ntrail_reg   <= next_trail_byte;
        end
        if (out_load)
            class_reg <= class_next;
    end

    // Classification of the registered character
    logic        ascii;
    logic        pre_ln;
    logic        prev_num;
    logic        next_dig;
    logic        next_ld;
    logic [15:0] code;
    logic [15:0] ncode;

    always_comb
    begin
        ascii    = !lead_reg[7];
        code     = {lead_reg, trail_reg};
        ncode    = {nlead_reg, ntrail_reg};
        prev_num = (prev_reg == CLS_NUMBER);
        pre_ln   = (prev_reg == CLS_LETTER) || prev_num;
        next_dig = has_next_reg && is_digit(nlead_reg, ntrail_reg);
        next_ld  = has_next_reg &&
                   (is_letter(nlead_reg, ntrail_reg) || next_dig);

        if (ascii && ((lead_reg == CH_DOT) || (lead_reg == CH_HYPHEN)))
            class_next = (pre_ln && next_ld) ? CLS_LETTER : CLS_PUNCT;
        else if (ascii && (lead_reg == CH_COMMA))
            class_next = (prev_num && next_dig) ? CLS_LETTER : CLS_PUNCT;
        else if (((code == CODE_OF) || (code == CODE_POINT)) && prev_num && next_dig)
            class_next = CLS_NUMBER;
        else if ((code == CODE_FRACTION) && has_next_reg && (ncode == CODE_OF))
            class_next = CLS_NUMBER;
        else if (((code == CODE_MANY) || (code == CODE_REMAIN)) && prev_num)
            class_next = CLS_NUMBER;
        else if (is_letter(lead_reg, trail_reg))
            class_next = CLS_LETTER;
        else if (is_digit(lead_reg, trail_reg))
            class_next = CLS_NUMBER;
        else if (is_punct(lead_reg, trail_reg))
            class_next = CLS_PUNCT;
        else if (is_space(lead_reg, trail_reg))
            class_next = CLS_SPACE;
        else if (is_date(lead_reg, trail_reg) && prev_num)
            class_next = CLS_DATE;
        else
            class_next = CLS_OTHER;
    end

endmodule

`default_nettype wire

/* sv/gbcct_checker.sv */
// Port-level checks for the character class tagger, bound to the top level.
// Depends on gbcct_pkg and the shared assertion macro header.
`default_nettype none
`include "gb2312_char_class_tagger_macros.svh"

module gbcct_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [2:0] char_class
);
    import gbcct_pkg::*;

    // A result beat never carries an unused class code
    `GBCCT_ASSERT_SAME(a_class_legal, out_valid, char_class <= CLS_DATE)

    // Hold a stalled result unchanged
    `GBCCT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(char_class))

    // An empty output register always lets the input side take a beat
    `GBCCT_ASSERT_SAME(a_ready_when_empty, !out_valid, in_ready)

    // A stall that persists while input is offered fills both stages, so input must stop
    `GBCCT_ASSERT_SAME(a_backpressure,
        out_valid && !out_ready && $past(out_valid && !out_ready && in_valid), !in_ready)

endmodule

bind gb2312_char_class_tagger gbcct_checker u_gbcct_checker (.*);

`default_nettype wire

/* verif/tb.sv */
// Self-checking testbench for gb2312_char_class_tagger: queued character beats
// are driven on the input channel and each result beat is checked against a
// local classifier. Depends on gbcct_pkg and the tagger RTL only.
`timescale 1ns / 100ps

module tb;
    import gbcct_pkg::*;

    localparam int CYCLE_LIMIT    = 400000;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int TAIL_CYCLES    = 10;

    typedef struct packed {
        logic [7:0] lead;
        logic [7:0] trail;
        logic [2:0] prev;
        logic       present;
        logic [7:0] nl;
        logic [7:0] nt;
    } char_beat_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] cur_lead_byte = 8'h00;
    logic [7:0] cur_trail_byte = 8'h00;
    logic [2:0] prev_class = 3'd0;
    logic       next_present = 1'b0;
    logic [7:0] next_lead_byte = 8'h00;
    logic [7:0] next_trail_byte = 8'h00;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [2:0] char_class;

    char_beat_t pend_beats[$];
    logic [2:0] class_q[$];
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    int         holdoff_req = 0;
    int         err_cnt = 0;
    int         cycle_cnt = 0;

    gb2312_char_class_tagger i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .cur_lead_byte   (cur_lead_byte),
        .cur_trail_byte  (cur_trail_byte),
        .prev_class      (prev_class),
        .next_present    (next_present),
        .next_lead_byte  (next_lead_byte),
        .next_trail_byte (next_trail_byte),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .char_class      (char_class)
    );

    function automatic logic in_span(input logic [7:0] v, input logic [7:0] lo,
                                     input logic [7:0] hi);
        return (v >= lo) && (v <= hi);
    endfunction

    function automatic logic [15:0] numeral_at(input int idx);
        case (idx)
            0:       return 16'ha1f0;
            1:       return 16'ha3ae;
            2:       return 16'ha3a5;
            3:       return 16'hc1e3;
            4:       return 16'hd2bb;
            5:       return 16'hb6fe;
            6:       return 16'hc8fd;
            7:       return 16'hcbc4;
            8:       return 16'hcee5;
            9:       return 16'hc1f9;
            10:      return 16'hc6df;
            11:      return 16'hb0cb;
            12:      return 16'hbec5;
            13:      return 16'hcaae;
            14:      return 16'hb0d9;
            15:      return 16'hc7a7;
            16:      return 16'hcdf2;
            default: return 16'hd2da;
        endcase
    endfunction

    function automatic logic [15:0] date_at(input int idx);
        case (idx)
            0:       return 16'hc4ea;
            1:       return 16'hd4c2;
            2:       return 16'hc8d5;
            3:       return 16'hcab1;
            4:       return 16'hb7d6;
            5:       return 16'hc3eb;
            default: return 16'hb5e3;
        endcase
    endfunction

    function automatic logic letter_char(input logic [7:0] lead, input logic [7:0] trail);
        if (!lead[7])
            return in_span(lead, 8'h41, 8'h5a) || in_span(lead, 8'h61, 8'h7a);
        return (lead == LEAD_FULL) &&
               (in_span(trail, 8'hc1, 8'hda) || in_span(trail, 8'he1, 8'hfa));
    endfunction

    function automatic logic numeral_char(input logic [7:0] lead, input logic [7:0] trail);
        if (in_span(lead, 8'h30, 8'h39) || (lead == CH_PCT) ||
            ((lead == LEAD_FULL) && in_span(trail, 8'hb0, 8'hb9)))
            return 1'b1;
        if (!lead[7])
            return 1'b0;
        for (int i = 0; i < 18; i++)
            if (numeral_at(i) == {lead, trail})
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic logic [2:0] predict_class(input char_beat_t b);
        logic [15:0] code;
        logic        pre_ln;
        logic        next_ld;
        logic        next_d;
        code    = {b.lead, b.trail};
        pre_ln  = (b.prev == CLS_LETTER) || (b.prev == CLS_NUMBER);
        next_d  = b.present && numeral_char(b.nl, b.nt);
        next_ld = b.present && (letter_char(b.nl, b.nt) || next_d);
        // Context rules first; single-byte codes never match the double-byte ones
        if (!b.lead[7]) begin
            if ((b.lead == CH_DOT) || (b.lead == CH_HYPHEN))
                return (pre_ln && next_ld) ? CLS_LETTER : CLS_PUNCT;
            if (b.lead == CH_COMMA)
                return ((b.prev == CLS_NUMBER) && next_d) ? CLS_LETTER : CLS_PUNCT;
        end else begin
            if (((code == CODE_OF) || (code == CODE_POINT)) &&
                (b.prev == CLS_NUMBER) && next_d)
                return CLS_NUMBER;
            if ((code == CODE_FRACTION) && b.present && ({b.nl, b.nt} == CODE_OF))
                return CLS_NUMBER;
            if (((code == CODE_MANY) || (code == CODE_REMAIN)) && (b.prev == CLS_NUMBER))
                return CLS_NUMBER;
        end
        if (letter_char(b.lead, b.trail))
            return CLS_LETTER;
        if (numeral_char(b.lead, b.trail))
            return CLS_NUMBER;
        if ((b.lead != CH_DOT) && (b.lead != CH_COMMA)) begin
            if (!b.lead[7]) begin
                if (in_span(b.lead, 8'h21, 8'h2f) || in_span(b.lead, 8'h3a, 8'h40) ||
                    in_span(b.lead, 8'h5b, 8'h60) || in_span(b.lead, 8'h7b, 8'h7e))
                    return CLS_PUNCT;
            end else if ((b.lead == LEAD_SYM) &&
                         (in_span(b.trail, 8'ha2, 8'hef) || in_span(b.trail, 8'hf1, 8'hfe)))
                return CLS_PUNCT;
            else if ((b.lead == LEAD_FULL) &&
                     (in_span(b.trail, 8'ha1, 8'haf) || in_span(b.trail, 8'hba, 8'hc0) ||
                      in_span(b.trail, 8'hdb, 8'he0) || in_span(b.trail, 8'hfb, 8'hfe)))
                return CLS_PUNCT;
        end
        if (!b.lead[7]) begin
            if ((b.lead == 8'h20) || in_span(b.lead, 8'h09, 8'h0d))
                return CLS_SPACE;
            return CLS_OTHER;
        end
        if ((b.lead == LEAD_SYM) && (b.trail == LEAD_SYM))
            return CLS_SPACE;
        for (int i = 0; i < 7; i++)
            if (date_at(i) == code)
                return (b.prev == CLS_NUMBER) ? CLS_DATE : CLS_OTHER;
        return CLS_OTHER;
    endfunction

    // Weighted towards characters that steer the context rules
    function automatic logic [15:0] pick_char();
        int         sel;
        logic [7:0] ld;
        logic [7:0] tr;
        sel = $urandom_range(0, 99);
        tr  = 8'($urandom);
        if (sel < 15) begin
            ld = 8'($urandom_range(8'h30, 8'h39));
            return {ld, tr};
        end
        if (sel < 25) begin
            if ($urandom_range(0, 1))
                ld = 8'($urandom_range(8'h41, 8'h5a));
            else
                ld = 8'($urandom_range(8'h61, 8'h7a));
            return {ld, tr};
        end
        if (sel < 35) begin
            case ($urandom_range(0, 2))
                0:       ld = CH_DOT;
                1:       ld = CH_COMMA;
                default: ld = CH_HYPHEN;
            endcase
            return {ld, tr};
        end
        if (sel < 45) begin
            case ($urandom_range(0, 4))
                0:       return CODE_OF;
                1:       return CODE_POINT;
                2:       return CODE_FRACTION;
                3:       return CODE_MANY;
                default: return CODE_REMAIN;
            endcase
        end
        if (sel < 53)
            return numeral_at($urandom_range(0, 17));
        if (sel < 59)
            return date_at($urandom_range(0, 6));
        if (sel < 67)
            return {LEAD_FULL, tr};
        if (sel < 73)
            return {LEAD_SYM, tr};
        if (sel < 85) begin
            ld = 8'($urandom_range(0, 127));
            return {ld, tr};
        end
        return 16'($urandom);
    endfunction

    task automatic add_beat(input logic [7:0] lead, input logic [7:0] trail,
                            input logic [2:0] prev, input logic present,
                            input logic [7:0] nl, input logic [7:0] nt);
        char_beat_t b;
        b.lead    = lead;
        b.trail   = trail;
        b.prev    = prev;
        b.present = present;
        b.nl      = nl;
        b.nt      = nt;
        pend_beats.push_back(b);
    endtask

    // Walk a synthetic text so that prev_class mostly follows the stream
    task automatic gen_text(input int n);
        logic [15:0] cur_ch;
        logic [15:0] nxt_ch;
        logic [2:0]  last_cls;
        char_beat_t  b;
        cur_ch   = pick_char();
        last_cls = CLS_OTHER;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < 15) begin
                b.lead    = 8'($urandom);
                b.trail   = 8'($urandom);
                b.prev    = 3'($urandom);
                b.present = 1'($urandom);
                b.nl      = 8'($urandom);
                b.nt      = 8'($urandom);
            end else begin
                nxt_ch    = pick_char();
                b.lead    = cur_ch[15:8];
                b.trail   = cur_ch[7:0];
                b.prev    = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7)) : last_cls;
                b.present = ($urandom_range(0, 19) != 0);
                b.nl      = nxt_ch[15:8];
                b.nt      = nxt_ch[7:0];
                last_cls  = predict_class(b);
                if (b.present)
                    cur_ch = nxt_ch;
                else
                begin
                    cur_ch   = pick_char();
                    last_cls = CLS_OTHER;
                end
            end
            pend_beats.push_back(b);
        end
    endtask

    task automatic wait_sent();
        while ((pend_beats.size() != 0) || in_valid)
            @(negedge clk);
    endtask

    task automatic wait_drained();
        wait_sent();
        while (class_q.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Driver: record the accepted beat, then offer the next one or idle
    always @(posedge clk or negedge rst_n)
    begin
        char_beat_t b;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                b.lead    = cur_lead_byte;
                b.trail   = cur_trail_byte;
                b.prev    = prev_class;
                b.present = next_present;
                b.nl      = next_lead_byte;
                b.nt      = next_trail_byte;
                class_q.push_back(predict_class(b));
            end
            if (!in_valid || in_ready) begin
                if ((pend_beats.size() != 0) && ($urandom_range(0, 99) >= send_idle_pct)) begin
                    b = pend_beats.pop_front();
                    cur_lead_byte   <= b.lead;
                    cur_trail_byte  <= b.trail;
                    prev_class      <= b.prev;
                    next_present    <= b.present;
                    next_lead_byte  <= b.nl;
                    next_trail_byte <= b.nt;
                    in_valid        <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result beat, then choose whether to stall
    always @(posedge clk or negedge rst_n)
    begin
        int holdoff_left;
        int holdoff_seen;
        logic [2:0] want;
        if (!rst_n) begin
            out_ready    <= 1'b0;
            holdoff_left = 0;
            holdoff_seen = 0;
        end else begin
            if (out_valid && out_ready) begin
                if (class_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got %0d",
                             $time, char_class);
                    err_cnt++;
                end else begin
                    want = class_q.pop_front();
                    if (char_class !== want) begin
                        $display("%0t: char_class mismatch, expected %0d, got %0d",
                                 $time, want, char_class);
                        err_cnt++;
                    end
                end
            end
            if (holdoff_seen != holdoff_req) begin
                holdoff_seen = holdoff_req;
                holdoff_left = HOLDOFF_CYCLES;
            end
            if (holdoff_left > 0) begin
                holdoff_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Separators between letters and digits, and at the end of text
        add_beat(CH_DOT, 8'h00, CLS_LETTER, 1'b1, 8'h61, 8'h00);
        add_beat(CH_DOT, 8'hff, CLS_NUMBER, 1'b1, 8'h37, 8'h00);
        add_beat(CH_DOT, 8'h00, CLS_LETTER, 1'b0, 8'h61, 8'h00);
        add_beat(CH_DOT, 8'h00, 3'd6, 1'b1, 8'h41, 8'h00);
        add_beat(CH_HYPHEN, 8'h00, CLS_NUMBER, 1'b1, LEAD_FULL, 8'hb5);
        add_beat(CH_HYPHEN, 8'h00, CLS_NUMBER, 1'b0, 8'h35, 8'h00);
        add_beat(CH_HYPHEN, 8'h00, CLS_OTHER, 1'b1, 8'h7a, 8'h00);
        add_beat(CH_COMMA, 8'h00, CLS_NUMBER, 1'b1, 8'h39, 8'h00);
        add_beat(CH_COMMA, 8'h00, CLS_LETTER, 1'b1, 8'h30, 8'h00);
        add_beat(CH_COMMA, 8'h00, CLS_NUMBER, 1'b0, 8'h30, 8'h00);
        // Chinese numeric connectors and date characters
        add_beat(CODE_POINT[15:8], CODE_POINT[7:0], CLS_NUMBER, 1'b1, 8'hc1, 8'he3);
        add_beat(CODE_POINT[15:8], CODE_POINT[7:0], CLS_NUMBER, 1'b0, 8'h31, 8'h00);
        add_beat(CODE_POINT[15:8], CODE_POINT[7:0], 3'd7, 1'b1, 8'h31, 8'h00);
        add_beat(CODE_OF[15:8], CODE_OF[7:0], CLS_NUMBER, 1'b1, 8'h35, 8'h00);
        add_beat(CODE_OF[15:8], CODE_OF[7:0], CLS_OTHER, 1'b1, 8'h35, 8'h00);
        add_beat(CODE_FRACTION[15:8], CODE_FRACTION[7:0], CLS_OTHER, 1'b1,
                 CODE_OF[15:8], CODE_OF[7:0]);
        add_beat(CODE_FRACTION[15:8], CODE_FRACTION[7:0], CLS_NUMBER, 1'b0,
                 CODE_OF[15:8], CODE_OF[7:0]);
        add_beat(CODE_MANY[15:8], CODE_MANY[7:0], CLS_NUMBER, 1'b0, 8'h00, 8'h00);
        add_beat(CODE_MANY[15:8], CODE_MANY[7:0], CLS_LETTER, 1'b1, 8'h31, 8'h00);
        add_beat(CODE_REMAIN[15:8], CODE_REMAIN[7:0], CLS_NUMBER, 1'b1, 8'h20, 8'h00);
        add_beat(8'hc4, 8'hea, CLS_NUMBER, 1'b1, 8'h20, 8'h00);
        add_beat(8'hc4, 8'hea, 3'd6, 1'b1, 8'h20, 8'h00);
        // Field extremes, null byte, spaces and full-width forms
        add_beat(8'h00, 8'h00, CLS_OTHER, 1'b0, 8'h00, 8'h00);
        add_beat(8'hff, 8'hff, 3'd7, 1'b1, 8'hff, 8'hff);
        add_beat(8'h7f, 8'h80, CLS_DATE, 1'b1, 8'h80, 8'h7f);
        add_beat(8'h20, 8'h00, CLS_SPACE, 1'b1, LEAD_SYM, LEAD_SYM);
        add_beat(LEAD_SYM, LEAD_SYM, CLS_PUNCT, 1'b1, LEAD_FULL, 8'hc1);
        add_beat(CH_PCT, 8'h00, CLS_OTHER, 1'b1, CH_DOT, 8'h00);
        wait_drained();

        gen_text(400);
        wait_sent();

        send_idle_pct = 71;
        gen_text(400);
        // Pause the sender until every result is back
        wait_drained();

        send_idle_pct  = 0;
        recv_stall_pct = 71;
        gen_text(400);
        wait_sent();

        send_idle_pct  = 22;
        recv_stall_pct = 22;
        gen_text(400);
        wait_drained();

        // Long receiver hold-off with the sender streaming: fill the pipe
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        holdoff_req    = holdoff_req + 1;
        gen_text(200);
        wait_drained();

        send_idle_pct  = 22;
        recv_stall_pct = 22;
        gen_text(150);
        wait_drained();

        repeat (TAIL_CYCLES) @(negedge clk);
        if ((err_cnt == 0) && (class_q.size() == 0))
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
